@@ src/keyframe_track_interpolator_assert.svh @@
// assertion macros for the keyframe track interpolator
// used by the controller and top level, no other dependencies
`ifndef KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH

// implication checked every clock edge, disabled in reset
`define KTI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define KTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/kti_pkg.sv @@
// shared types and constants for the keyframe track interpolator
// no dependencies
package kti_pkg;

  typedef struct packed {
    logic               action;
    logic        [31:0] key_frame;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [15:0] in_rot_w;
    logic signed [15:0] in_rot_x;
    logic signed [15:0] in_rot_y;
    logic signed [15:0] in_rot_z;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_rot_w;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
    logic        [31:0] track_max_frame;
  } out_item_t;

  localparam logic [2:0] StAdded  = 3'd0;
  localparam logic [2:0] StFull   = 3'd1;
  localparam logic [2:0] StInterp = 3'd2;
  localparam logic [2:0] StSingle = 3'd3;
  localparam logic [2:0] StNone   = 3'd4;

  localparam logic ActAdd   = 1'b0;
  localparam logic ActQuery = 1'b1;

  localparam int EntryW = 32 + 96 + 64;
  localparam logic signed [15:0] RotOne = 16'sd16384;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone,
    CmdLatch,     // capture the transaction
    CmdRdIdx,     // read entry at index
    CmdShift,     // write held entry at index+1, index--
    CmdInsert,    // write new key at index+1, count++
    CmdLoadA,     // held read data -> side a, index++
    CmdLoadB,     // held read data -> side b
    CmdDivStart,
    CmdDivStep,
    CmdMix,       // one component multiply-accumulate
    CmdFinish
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] status;
    logic       zero_pay;  // zero payload result
    logic       id_pay;    // identity result
    logic       a_pay;     // pass side a unchanged
  } ctl_t;

  typedef struct packed {
    logic action;
    logic full;
    logic idx_zero;
    logic rd_gt;     // read frame > q
    logic rd_lt;     // read frame < q
    logic count_one;
    logic last_pair; // entry at idx is the last one held
    logic count_lt2;
    logic div_done;
    logic mix_done;
  } sts_t;

endpackage

@@ src/keyframe_track_interpolator.sv @@
// keyframe track interpolator usage notes:
// input channel in_valid_i / in_stall_o carries one transaction (kti_pkg::in_item_t):
//   action 0 adds a key, action 1 queries the track at key_frame
// output channel out_valid_o / out_stall_i returns one result per transaction
// one transaction at a time: in_stall_o is high from acceptance until the
//   result is taken, and the next transaction is taken the cycle after
// add: walks down the sorted store from the top entry, each entry looked at
//   (up to the key count) passing a read, a wait and a check state, then
//   writes the key; an add dropped on a full track answers without a walk
// query: scans up from entry zero, a read and a check state per entry (up to
//   the key count), with the ram's registered read; no bracket or a single key
//   answers when the scan ends, a bracket adds a 48-step serial divider and
//   7 blend steps
// a stalled result is held steady until taken
// reset empties the track and clears the largest frame; the store needs
//   no clearing since only entries below the key count are read
// depends on kti_pkg, kti_ctrl, kti_datapath, kti_ram
`include "keyframe_track_interpolator_assert.svh"
module keyframe_track_interpolator #(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kti_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kti_pkg::out_item_t out_data_o
);
  kti_pkg::ctl_t ctl;
  kti_pkg::sts_t sts;

  kti_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  kti_datapath #(.MaxKeys(MAX_KEYS)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .ctl_i(ctl), .sts_o(sts), .res_o(out_data_o)
  );

  // the largest frame never falls
  `KTI_ASSERT_NEXT(a_max_mono, 1'b1,
                   out_data_o.track_max_frame >= $past(out_data_o.track_max_frame))
endmodule

@@ src/kti_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module kti_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ src/kti_datapath.sv @@
// datapath: key store, divider and blend unit
// depends on kti_pkg and kti_ram
module kti_datapath #(
  parameter int MaxKeys = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kti_pkg::in_item_t in_i,
  input  kti_pkg::ctl_t     ctl_i,
  output kti_pkg::sts_t     sts_o,
  output kti_pkg::out_item_t res_o
);
  localparam int AW = $clog2(MaxKeys);
  localparam int CW = $clog2(MaxKeys + 1);

  kti_pkg::in_item_t in_q;
  logic [CW-1:0] count_q;
  logic [31:0]   maxf_q;
  logic [CW-1:0] idx_q;
  logic          we;
  logic [AW-1:0] addr;
  logic [kti_pkg::EntryW-1:0] wdata, rdata, ea_q, eb_q;
  logic [CW-1:0] idx_p1;
  logic [31:0]   rd_f;

  // divider
  logic [47:0] num_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [16:0] quo_q;
  logic [5:0]  dcnt_q;
  logic [32:0] rem_sh;
  logic [33:0] trial;

  // blend
  logic [2:0]  comp_q;
  logic signed [31:0] ca, cb;
  logic signed [49:0] pa, pb;
  logic signed [50:0] sum;
  logic signed [31:0] mixed;
  logic signed [31:0] rp_q [3];
  logic signed [15:0] rr_q [4];

  assign idx_p1 = idx_q + CW'(1);
  assign rd_f   = rdata[kti_pkg::EntryW-1 -: 32];

  // during an add the free slot sits just above idx, which wraps below zero
  always_comb begin
    we    = 1'b0;
    addr  = idx_q[AW-1:0];
    wdata = rdata;
    case (ctl_i.cmd)
      kti_pkg::CmdShift: begin
        we = 1'b1;
        addr = idx_p1[AW-1:0];
      end
      kti_pkg::CmdInsert: begin
        we = 1'b1;
        addr = idx_p1[AW-1:0];
        wdata = {in_q.key_frame, in_q.in_pos_x, in_q.in_pos_y, in_q.in_pos_z,
                 in_q.in_rot_w, in_q.in_rot_x, in_q.in_rot_y, in_q.in_rot_z};
      end
      default: ;
    endcase
  end

  kti_ram #(.Width(kti_pkg::EntryW), .Depth(MaxKeys)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign rem_sh = {rem_q[31:0], num_q[47]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den_q};

  always_comb begin
    ca = '0;
    cb = '0;
    case (comp_q)
      3'd0: begin ca = ea_q[159:128]; cb = eb_q[159:128]; end
      3'd1: begin ca = ea_q[127:96];  cb = eb_q[127:96];  end
      3'd2: begin ca = ea_q[95:64];   cb = eb_q[95:64];   end
      3'd3: begin ca = 32'(signed'(ea_q[63:48])); cb = 32'(signed'(eb_q[63:48])); end
      3'd4: begin ca = 32'(signed'(ea_q[47:32])); cb = 32'(signed'(eb_q[47:32])); end
      3'd5: begin ca = 32'(signed'(ea_q[31:16])); cb = 32'(signed'(eb_q[31:16])); end
      3'd6: begin ca = 32'(signed'(ea_q[15:0]));  cb = 32'(signed'(eb_q[15:0]));  end
      default: ;
    endcase
    pa    = ca * signed'({1'b0, quo_q});
    pb    = cb * signed'({1'b0, 17'h10000 - quo_q});
    sum   = 51'(pa) + 51'(pb);
    mixed = sum[47:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      maxf_q  <= '0;
      idx_q   <= '0;
      dcnt_q  <= '0;
      comp_q  <= '0;
    end else begin
      case (ctl_i.cmd)
        kti_pkg::CmdLatch: begin
          idx_q <= (in_i.action == kti_pkg::ActAdd) ? count_q - CW'(1) : '0;
          comp_q <= '0;
        end
        kti_pkg::CmdShift: idx_q <= idx_q - CW'(1);
        kti_pkg::CmdInsert: begin
          count_q <= count_q + CW'(1);
          if (in_q.key_frame > maxf_q) maxf_q <= in_q.key_frame;
        end
        kti_pkg::CmdLoadA: idx_q <= idx_p1;
        kti_pkg::CmdLoadB: idx_q <= idx_q;
        kti_pkg::CmdDivStart: dcnt_q <= 6'd48;
        kti_pkg::CmdDivStep: dcnt_q <= dcnt_q - 6'd1;
        kti_pkg::CmdMix: comp_q <= comp_q + 3'd1;
        default: ;
      endcase
    end
  end

  // transaction, pair, divider and blend registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      kti_pkg::CmdLatch: in_q <= in_i;
      kti_pkg::CmdLoadA: ea_q <= rdata;
      kti_pkg::CmdLoadB: eb_q <= rdata;
      kti_pkg::CmdDivStart: begin
        num_q <= {eb_q[191:160] - in_q.key_frame, 16'h0};
        den_q <= eb_q[191:160] - ea_q[191:160];
        rem_q <= '0;
        quo_q <= '0;
      end
      kti_pkg::CmdDivStep: begin
        num_q <= {num_q[46:0], 1'b0};
        if (!trial[33]) begin
          rem_q <= trial[32:0];
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[15:0], 1'b0};
        end
      end
      kti_pkg::CmdMix: begin
        if (comp_q < 3'd3) rp_q[comp_q[1:0]] <= mixed;
        else rr_q[2'(comp_q - 3'd3)] <= mixed[15:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.action    = in_q.action;
    sts_o.full      = (count_q == CW'(MaxKeys));
    sts_o.idx_zero  = (idx_q == '0);
    sts_o.rd_gt     = (rd_f > in_q.key_frame);
    sts_o.rd_lt     = (rd_f < in_q.key_frame);
    sts_o.count_one = (count_q == CW'(1));
    sts_o.last_pair = ((idx_q + CW'(1)) >= count_q);
    sts_o.count_lt2 = (count_q < CW'(2));
    sts_o.div_done  = (dcnt_q == 6'd1);
    sts_o.mix_done  = (comp_q == 3'd6);
  end

  always_comb begin
    res_o.status          = ctl_i.status;
    res_o.track_max_frame = maxf_q;
    res_o.out_pos_x = rp_q[0];
    res_o.out_pos_y = rp_q[1];
    res_o.out_pos_z = rp_q[2];
    res_o.out_rot_w = rr_q[0];
    res_o.out_rot_x = rr_q[1];
    res_o.out_rot_y = rr_q[2];
    res_o.out_rot_z = rr_q[3];
    if (ctl_i.zero_pay || ctl_i.id_pay) begin
      res_o.out_pos_x = '0;
      res_o.out_pos_y = '0;
      res_o.out_pos_z = '0;
      res_o.out_rot_w = ctl_i.id_pay ? kti_pkg::RotOne : '0;
      res_o.out_rot_x = '0;
      res_o.out_rot_y = '0;
      res_o.out_rot_z = '0;
    end else if (ctl_i.a_pay) begin
      res_o.out_pos_x = ea_q[159:128];
      res_o.out_pos_y = ea_q[127:96];
      res_o.out_pos_z = ea_q[95:64];
      res_o.out_rot_w = ea_q[63:48];
      res_o.out_rot_x = ea_q[47:32];
      res_o.out_rot_y = ea_q[31:16];
      res_o.out_rot_z = ea_q[15:0];
    end
  end
endmodule

@@ src/kti_ctrl.sv @@
// controller state machine for insert, search, divide and blend
// depends on kti_pkg and the assertion header
`include "keyframe_track_interpolator_assert.svh"
module kti_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  kti_pkg::sts_t sts_i,
  output kti_pkg::ctl_t ctl_o
);
  typedef enum logic [3:0] {
    SIdle, SDecide, SInsRd, SInsWait, SInsChk, SInsPut,
    SQRd, SQChk, SDivInit, SDiv, SMix, SDone
  } state_e;

  // result payload source
  typedef enum logic [1:0] {
    PayMix, PayZero, PayId, PayA
  } pay_e;

  state_e     state_q, state_d;
  logic [2:0] st_q, st_d;
  pay_e       pay_q, pay_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    pay_d   = pay_q;
    ctl_o.cmd      = kti_pkg::CmdNone;
    ctl_o.status   = st_q;
    ctl_o.zero_pay = (pay_q == PayZero);
    ctl_o.id_pay   = (pay_q == PayId);
    ctl_o.a_pay    = (pay_q == PayA);
    case (state_q)
      SIdle: if (in_valid_i) begin
        ctl_o.cmd = kti_pkg::CmdLatch;
        state_d = SDecide;
      end
      SDecide: begin
        if (sts_i.action == kti_pkg::ActAdd) begin
          pay_d = PayZero;
          if (sts_i.full) begin
            st_d = kti_pkg::StFull; state_d = SDone;
          end else begin
            st_d = kti_pkg::StAdded;
            // idx holds count-1; empty track wraps, insert at zero
            state_d = sts_i.count_lt2 && !sts_i.count_one ? SInsPut : SInsRd;
          end
        end else if (sts_i.count_lt2 && !sts_i.count_one) begin
          st_d = kti_pkg::StNone; pay_d = PayId; state_d = SDone;
        end else begin
          state_d = SQRd;
        end
      end
      SInsRd: state_d = SInsWait;
      SInsWait: state_d = SInsChk;
      SInsChk: begin
        if (sts_i.rd_gt) begin
          ctl_o.cmd = kti_pkg::CmdShift;
          state_d = sts_i.idx_zero ? SInsPut : SInsRd;
        end else begin
          state_d = SInsPut; // free slot sits just above idx
        end
      end
      SInsPut: begin
        ctl_o.cmd = kti_pkg::CmdInsert;
        st_d = kti_pkg::StAdded;
        state_d = SDone;
      end
      // scan up for the first frame above q; side a trails one entry behind
      SQRd: state_d = SQChk;
      SQChk: begin
        if (sts_i.rd_gt) begin
          if (sts_i.idx_zero) begin
            st_d = kti_pkg::StNone; pay_d = PayId; state_d = SDone;
          end else begin
            ctl_o.cmd = kti_pkg::CmdLoadB;
            state_d = SDivInit;
          end
        end else begin
          ctl_o.cmd = kti_pkg::CmdLoadA;
          if (sts_i.last_pair) begin
            if (sts_i.count_one && sts_i.rd_lt) begin
              st_d = kti_pkg::StSingle; pay_d = PayA;
            end else begin
              st_d = kti_pkg::StNone; pay_d = PayId;
            end
            state_d = SDone;
          end else begin
            state_d = SQRd;
          end
        end
      end
      SDivInit: begin
        ctl_o.cmd = kti_pkg::CmdDivStart;
        state_d = SDiv;
      end
      SDiv: begin
        ctl_o.cmd = kti_pkg::CmdDivStep;
        if (sts_i.div_done) state_d = SMix;
      end
      SMix: begin
        ctl_o.cmd = kti_pkg::CmdMix;
        if (sts_i.mix_done) begin
          st_d = kti_pkg::StInterp; pay_d = PayMix; state_d = SDone;
        end
      end
      SDone: if (!out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      st_q    <= '0;
      pay_q   <= PayMix;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      pay_q   <= pay_d;
    end
  end

  assign in_stall_o   = (state_q != SIdle);
  assign out_valid_o  = (state_q == SDone);

  `KTI_ASSERT_IMP(a_ready_only_idle, !in_stall_o, state_q == SIdle)
  `KTI_ASSERT_NEXT(a_done_holds, out_valid_o && out_stall_i, out_valid_o)
  `KTI_ASSERT_IMP(a_no_both, out_valid_o, in_stall_o)
endmodule

@@ dv/tb_keyframe_track_interpolator.sv @@
// self-checking testbench for the keyframe track interpolator
// depends on kti_pkg and the keyframe_track_interpolator top level
`timescale 1ns / 1ps
module tb_keyframe_track_interpolator;

  localparam int KeyDepth = 64;
  localparam int NumRandom = 1430;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  kti_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  kti_pkg::out_item_t out_data_o;

  keyframe_track_interpolator #(.MAX_KEYS(KeyDepth)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor's own copy of the track
  logic        [31:0] trk_frame [KeyDepth];
  logic signed [31:0] trk_pos   [KeyDepth][3];
  logic signed [15:0] trk_rot   [KeyDepth][4];
  int unsigned        trk_count;
  logic        [31:0] trk_max;

  kti_pkg::out_item_t pending_results[$];
  int        error_count;
  bit        stim_done;
  bit        sink_hold;   // long receiver hold-off request
  bit        calm_phase;  // stretch with no idling

  // floor of (a*s + b*(65536-s)) / 65536
  function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
                                               logic signed [63:0] s);
    logic signed [63:0] v;
    v = a * s + b * (64'sd65536 - s);
    return v >>> 16;
  endfunction

  // apply one transaction to the track copy and work out its result
  function automatic kti_pkg::out_item_t track_step(kti_pkg::in_item_t it);
    kti_pkg::out_item_t r;
    int at;
    logic [31:0] f0, f1, q;
    logic [63:0] num;
    logic signed [63:0] s;
    r = '0;
    q = it.key_frame;
    if (it.action == kti_pkg::ActAdd) begin
      if (trk_count >= KeyDepth) begin
        r.status = kti_pkg::StFull;
      end else begin
        at = int'(trk_count);
        while (at > 0 && trk_frame[at-1] > q) begin
          trk_frame[at] = trk_frame[at-1];
          trk_pos[at]   = trk_pos[at-1];
          trk_rot[at]   = trk_rot[at-1];
          at--;
        end
        trk_frame[at]  = q;
        trk_pos[at][0] = it.in_pos_x;
        trk_pos[at][1] = it.in_pos_y;
        trk_pos[at][2] = it.in_pos_z;
        trk_rot[at][0] = it.in_rot_w;
        trk_rot[at][1] = it.in_rot_x;
        trk_rot[at][2] = it.in_rot_y;
        trk_rot[at][3] = it.in_rot_z;
        trk_count++;
        if (q > trk_max) trk_max = q;
        r.status = kti_pkg::StAdded;
      end
    end else begin
      r.status = kti_pkg::StNone;
      r.out_rot_w = kti_pkg::RotOne;
      if (trk_count == 1 && trk_frame[0] < q) begin
        r.status = kti_pkg::StSingle;
        r.out_pos_x = trk_pos[0][0];
        r.out_pos_y = trk_pos[0][1];
        r.out_pos_z = trk_pos[0][2];
        r.out_rot_w = trk_rot[0][0];
        r.out_rot_x = trk_rot[0][1];
        r.out_rot_y = trk_rot[0][2];
        r.out_rot_z = trk_rot[0][3];
      end else begin
        for (int i = 0; i + 1 < trk_count; i++) begin
          f0 = trk_frame[i];
          f1 = trk_frame[i+1];
          if (f0 <= q && f1 > q) begin
            num = {32'd0, f1 - q} << 16;
            s = $signed(num / {32'd0, f1 - f0});
            r.out_pos_x = 32'(blend(trk_pos[i][0], trk_pos[i+1][0], s));
            r.out_pos_y = 32'(blend(trk_pos[i][1], trk_pos[i+1][1], s));
            r.out_pos_z = 32'(blend(trk_pos[i][2], trk_pos[i+1][2], s));
            r.out_rot_w = 16'(blend(trk_rot[i][0], trk_rot[i+1][0], s));
            r.out_rot_x = 16'(blend(trk_rot[i][1], trk_rot[i+1][1], s));
            r.out_rot_y = 16'(blend(trk_rot[i][2], trk_rot[i+1][2], s));
            r.out_rot_z = 16'(blend(trk_rot[i][3], trk_rot[i+1][3], s));
            r.status = kti_pkg::StInterp;
            break;
          end
        end
      end
    end
    r.track_max_frame = trk_max;
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // limit on the whole run
  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  // directed rows: golden result typed in where obvious, else predictor
  typedef struct {
    kti_pkg::in_item_t  item;
    bit                 has_gold;
    kti_pkg::out_item_t gold;
  } dir_row_t;

  dir_row_t dir_table[$];

  function automatic kti_pkg::in_item_t mk(logic act, logic [31:0] f, logic [31:0] px,
                                           logic [15:0] rw, logic [15:0] rx);
    kti_pkg::in_item_t it;
    it = '0;
    it.action = act;   it.key_frame = f;
    it.in_pos_x = px;  it.in_pos_y = ~px; it.in_pos_z = px ^ 32'h5555_5555;
    it.in_rot_w = rw;  it.in_rot_x = rx;  it.in_rot_y = ~rx; it.in_rot_z = rw ^ rx;
    return it;
  endfunction

  function automatic void add_row(kti_pkg::in_item_t it, bit g, kti_pkg::out_item_t go);
    dir_row_t r;
    r.item = it; r.has_gold = g; r.gold = go;
    dir_table.insert(dir_table.size(), r);
  endfunction

  function automatic kti_pkg::out_item_t none_res(logic [31:0] mx);
    kti_pkg::out_item_t r;
    r = '0; r.status = kti_pkg::StNone; r.out_rot_w = kti_pkg::RotOne;
    r.track_max_frame = mx;
    return r;
  endfunction

  function automatic kti_pkg::out_item_t add_res(logic [31:0] mx);
    kti_pkg::out_item_t r;
    r = '0; r.status = kti_pkg::StAdded; r.track_max_frame = mx;
    return r;
  endfunction

  function automatic void build_table();
    // empty track queries give identity
    add_row(mk(kti_pkg::ActQuery, 32'd0, 32'h1234, 16'h1, 16'h2), 1, none_res(32'd0));
    add_row(mk(kti_pkg::ActQuery, 32'hFFFF_FFFF, '1, '1, '1), 1, none_res(32'd0));
    add_row(mk(kti_pkg::ActAdd, 32'd100, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000), 1,
            add_res(32'd100));
    // single key: at its frame no bracket, above it held
    add_row(mk(kti_pkg::ActQuery, 32'd100, '0, '0, '0), 1, none_res(32'd100));
    add_row(mk(kti_pkg::ActQuery, 32'd99, '0, '0, '0), 1, none_res(32'd100));
    add_row(mk(kti_pkg::ActQuery, 32'd101, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActAdd, 32'd200, 32'h8000_0000, 16'h8000, 16'h7FFF), 1,
            add_res(32'd200));
    add_row(mk(kti_pkg::ActQuery, 32'd100, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActQuery, 32'd150, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActQuery, 32'd199, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActQuery, 32'd200, '0, '0, '0), 1, none_res(32'd200));
    // equal frames placed after existing, out of order insert
    add_row(mk(kti_pkg::ActAdd, 32'd100, 32'h0001_0000, 16'h4000, 16'h0), 1,
            add_res(32'd200));
    add_row(mk(kti_pkg::ActAdd, 32'd0, 32'hFFFF_0000, 16'hC000, 16'h1), 1,
            add_res(32'd200));
    add_row(mk(kti_pkg::ActQuery, 32'd100, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActQuery, 32'd50, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActAdd, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 16'h5A5A, 16'hA5A5), 1,
            add_res(32'hFFFF_FFFF));
    add_row(mk(kti_pkg::ActQuery, 32'hFFFF_FFFE, '0, '0, '0), 0, '0);
    add_row(mk(kti_pkg::ActQuery, 32'd0, '0, '0, '0), 0, '0);
  endfunction

  // sender
  task automatic send_item(kti_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), track_step(it));
  endtask

  task automatic sender_gap();
    if (!calm_phase && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '{default: '0};
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic kti_pkg::in_item_t rand_item(int unsigned fspan);
    kti_pkg::in_item_t it;
    it.action    = ($urandom_range(0, 99) < 55);
    it.key_frame = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, fspan);
    it.in_pos_x  = $urandom();
    it.in_pos_y  = $urandom();
    it.in_pos_z  = $urandom();
    it.in_rot_w  = 16'($urandom());
    it.in_rot_x  = 16'($urandom());
    it.in_rot_y  = 16'($urandom());
    it.in_rot_z  = 16'($urandom());
    return it;
  endfunction

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin
    kti_pkg::in_item_t it;
    int n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    stim_done   = 1'b0;
    sink_hold   = 1'b0;
    calm_phase  = 1'b0;
    error_count = 0;
    trk_count   = 0;
    trk_max     = '0;
    build_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, golden rows replace the predicted value
    foreach (dir_table[k]) begin
      send_item(dir_table[k].item);
      if (dir_table[k].has_gold) pending_results[$] = dir_table[k].gold;
      sender_gap();
    end

    // random part; the track fills early, later adds mostly hit the full case
    n = 0;
    while (n < NumRandom) begin
      if (n == 300) begin
        // sender pauses until every expected result is back
        drain_wait();
        // receiver holds off long while sender keeps offering
        sink_hold = 1'b1;
      end
      calm_phase = (n >= 600 && n < 800);
      it = rand_item((n < 700) ? 2000 : 300);
      // drive the table to full during one stretch to hit dropped adds
      if (n >= 900 && n < 1000) it.action = kti_pkg::ActAdd;
      send_item(it);
      n++;
      sender_gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      out_stall_i <= (!calm_phase && $urandom_range(0, 99) < 25);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    kti_pkg::out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o !== exp_res) begin
          $display("%0t mismatch expected %p actual %p", $time, exp_res, out_data_o);
          error_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ keyframe_track_interpolator.f @@
+incdir+src
src/kti_pkg.sv
src/kti_ram.sv
src/kti_datapath.sv
src/kti_ctrl.sv
src/keyframe_track_interpolator.sv
dv/tb_keyframe_track_interpolator.sv
